// ===== rtl/core/mmnp_pkg.sv =====
// Shared types, constants and lookup functions of the music-macro note parser.
// No dependencies; every other file of the block refers to it by scoped names.
package mmnp_pkg;

  localparam int VOICES_DEF  = 4;
  localparam int PITCH_DEF   = 72;
  localparam int TABLE_SIZE  = 72;
  localparam int LEN_W       = 24;
  localparam int PROD_W      = 40;   // 16-bit scale times 24-bit length
  localparam int CNT_W       = 6;
  localparam int POS_W       = 32;

  // 3600 frames per minute in Q16.16 over 4096 length units per quarter
  localparam logic [15:0] FRAME_SCALE = 16'd57600;
  localparam logic [7:0]  MIN_TEMPO   = 8'd30;
  localparam logic [7:0]  MAX_TEMPO   = 8'd250;
  localparam logic [7:0]  TEMPO_RESET = 8'd120;
  localparam logic [23:0] LEN_RESET   = 24'd4096;
  localparam logic [7:0]  DUTY_BASE   = 8'd128;
  localparam logic [7:0]  HIGH_BASE   = 8'd48;

  typedef enum logic [1:0] {
    EV_NOTE  = 2'd0,
    EV_REST  = 2'd1,
    EV_ERROR = 2'd2
  } event_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE    = 4'd0,
    ERR_TEMPO   = 4'd1,
    ERR_OCTAVE  = 4'd2,
    ERR_MCMD    = 4'd3,
    ERR_VOLUME  = 4'd4,
    ERR_NOTELEN = 4'd5,
    ERR_RESTLEN = 4'd6,
    ERR_SYNTAX  = 4'd7,
    ERR_PITCH   = 4'd8
  } error_code_t;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_TEMPO   = 9'b000000010,
    PH_OCT     = 9'b000000100,
    PH_VOL     = 9'b000001000,
    PH_LEN     = 9'b000010000,
    PH_RESTNUM = 9'b000100000,
    PH_RESTDOT = 9'b001000000,
    PH_NOTEACC = 9'b010000000,
    PH_NOTEDOT = 9'b100000000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_REC  = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic decode;
    logic start_mul;
    logic div_step;
    logic load_rec;
    logic load_err;
  } dp_cmd_t;

  typedef struct packed {
    logic has_rec;
    logic has_err;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [10:0] period_lookup(input logic [6:0] idx);
    logic [10:0] p;
    case (idx)
      7'd0:  p = 11'd2033; 7'd1:  p = 11'd1928; 7'd2:  p = 11'd1803; 7'd3:  p = 11'd1720;
      7'd4:  p = 11'd1620; 7'd5:  p = 11'd1531; 7'd6:  p = 11'd1433; 7'd7:  p = 11'd1363;
      7'd8:  p = 11'd1285; 7'd9:  p = 11'd1215; 7'd10: p = 11'd1140; 7'd11: p = 11'd1075;
      7'd12: p = 11'd1016; 7'd13: p = 11'd955;  7'd14: p = 11'd908;  7'd15: p = 11'd853;
      7'd16: p = 11'd804;  7'd17: p = 11'd760;  7'd18: p = 11'd716;  7'd19: p = 11'd677;
      7'd20: p = 11'd638;  7'd21: p = 11'd604;  7'd22: p = 11'd570;  7'd23: p = 11'd537;
      7'd24: p = 11'd507;  7'd25: p = 11'd479;  7'd26: p = 11'd452;  7'd27: p = 11'd426;
      7'd28: p = 11'd403;  7'd29: p = 11'd379;  7'd30: p = 11'd359;  7'd31: p = 11'd339;
      7'd32: p = 11'd320;  7'd33: p = 11'd301;  7'd34: p = 11'd248;  7'd35: p = 11'd269;
      7'd36: p = 11'd253;  7'd37: p = 11'd239;  7'd38: p = 11'd225;  7'd39: p = 11'd213;
      7'd40: p = 11'd201;  7'd41: p = 11'd190;  7'd42: p = 11'd179;  7'd43: p = 11'd169;
      7'd44: p = 11'd159;  7'd45: p = 11'd150;  7'd46: p = 11'd142;  7'd47: p = 11'd134;
      7'd48: p = 11'd126;  7'd49: p = 11'd119;  7'd50: p = 11'd112;  7'd51: p = 11'd106;
      7'd52: p = 11'd100;  7'd53: p = 11'd94;   7'd54: p = 11'd89;   7'd55: p = 11'd84;
      7'd56: p = 11'd79;   7'd57: p = 11'd75;   7'd58: p = 11'd70;   7'd59: p = 11'd66;
      7'd60: p = 11'd63;   7'd61: p = 11'd59;   7'd62: p = 11'd56;   7'd63: p = 11'd52;
      7'd64: p = 11'd49;   7'd65: p = 11'd47;   7'd66: p = 11'd44;   7'd67: p = 11'd41;
      7'd68: p = 11'd39;   7'd69: p = 11'd37;   7'd70: p = 11'd35;   7'd71: p = 11'd33;
      default: p = 11'd0;
    endcase
    return p;
  endfunction

  function automatic logic [23:0] length_code(input logic [15:0] n);
    logic [23:0] l;
    case (n)
      16'd1:   l = 24'd16384;
      16'd2:   l = 24'd8192;
      16'd4:   l = 24'd4096;
      16'd8:   l = 24'd2048;
      16'd16:  l = 24'd1024;
      default: l = 24'd0;
    endcase
    return l;
  endfunction

  // dotted length: l + l/2, saturating
  function automatic logic [23:0] grow(input logic [23:0] l);
    logic [24:0] s;
    s = {1'b0, l} + {2'b00, l[23:1]};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic logic [4:0] semitone_of(input logic [2:0] letter);
    logic [4:0] s;
    case (letter)
      3'd0:    s = 5'd9;
      3'd1:    s = 5'd11;
      3'd2:    s = 5'd0;
      3'd3:    s = 5'd2;
      3'd4:    s = 5'd4;
      3'd5:    s = 5'd5;
      3'd6:    s = 5'd7;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/mmnp_ctrl.sv =====
// Sequencing state machine of the music-macro note parser.
// Depends on mmnp_pkg; drives the commands of mmnp_dp and reads its status.
module mmnp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmnp_pkg::dp_stat_t stat,
  output mmnp_pkg::dp_cmd_t  cmd
);

  mmnp_pkg::ctrl_state_t state_r, state_nxt;

  assign in_stall = (state_r != mmnp_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      mmnp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.decode = 1'b1;
          state_nxt  = mmnp_pkg::S_DISP;
        end
      end
      mmnp_pkg::S_DISP: begin
        if (stat.has_rec) begin
          state_nxt = mmnp_pkg::S_MUL;
        end else if (stat.has_err) begin
          state_nxt = mmnp_pkg::S_REC;
        end else begin
          state_nxt = mmnp_pkg::S_IDLE;
        end
      end
      mmnp_pkg::S_MUL: begin
        cmd.start_mul = 1'b1;
        state_nxt     = mmnp_pkg::S_DIV;
      end
      mmnp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = mmnp_pkg::S_REC;
        end
      end
      mmnp_pkg::S_REC: begin
        // note/rest record first, error record after it
        if (stat.out_free) begin
          if (stat.has_rec) begin
            cmd.load_rec = 1'b1;
            state_nxt    = stat.has_err ? mmnp_pkg::S_REC : mmnp_pkg::S_IDLE;
          end else begin
            cmd.load_err = 1'b1;
            state_nxt    = mmnp_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = mmnp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmnp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_mul_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mmnp_pkg::S_MUL |=> state_r == mmnp_pkg::S_DIV)
    else $error("multiply not followed by divide");
  a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mmnp_pkg::S_DIV && !stat.div_last) |=> state_r == mmnp_pkg::S_DIV)
    else $error("divide left early");
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_rec && cmd.load_err))
    else $error("two record loads in one cycle");

endmodule

// ===== rtl/core/mmnp_dp.sv =====
// Datapath of the music-macro note parser: character decode, parser state,
// length scaling multiplier, bit-serial tempo divider, frame positions, output register.
// Depends on mmnp_pkg; controlled by mmnp_ctrl.
module mmnp_dp #(
  parameter int VOICES        = mmnp_pkg::VOICES_DEF,
  parameter int PITCH_ENTRIES = mmnp_pkg::PITCH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mmnp_pkg::dp_cmd_t  cmd,
  output mmnp_pkg::dp_stat_t stat,
  input  logic [7:0]         in_char_code,
  input  logic [1:0]         in_voice,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [7:0]         out_frame_count,
  output logic [7:0]         out_voice_mask,
  output logic [7:0]         out_duty_volume,
  output logic [0:0]         out_sweep_byte,
  output logic [7:0]         out_timer_low,
  output logic [7:0]         out_timer_high_load,
  output logic [3:0]         out_error_code,
  output logic               out_last
);

  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;

  // parser state
  logic [7:0]                       tempo_r, tempo_nxt;
  logic [4:0]                       vol_r, vol_nxt;
  logic [4:0]                       oct_r, oct_nxt;
  logic [mmnp_pkg::LEN_W-1:0]       deflen_r, deflen_nxt;
  mmnp_pkg::phase_t                 phase_r, phase_nxt;
  logic [15:0]                      digit_r, digit_nxt;
  logic [4:0]                       semi_r, semi_nxt;
  logic [mmnp_pkg::LEN_W-1:0]       plen_r, plen_nxt;
  logic                             halted_r;
  logic [mmnp_pkg::POS_W-1:0]       pos_r [VOICES];

  // latched outcome of one character
  logic                             has_rec_r;
  mmnp_pkg::error_code_t            err_r;
  mmnp_pkg::event_kind_t            rkind_r;
  logic [mmnp_pkg::LEN_W-1:0]       rlen_r;
  logic [VW-1:0]                    rvoice_r;
  logic [7:0]                       rduty_r, rtlo_r, rthi_r;

  // divider
  logic [mmnp_pkg::PROD_W-1:0]      dvd_r;
  logic [7:0]                       rem_r;
  logic [mmnp_pkg::CNT_W-1:0]       cnt_r;

  // output register
  logic                             ov_r;
  mmnp_pkg::event_kind_t            o_kind_r;
  logic [7:0]                       o_frames_r, o_mask_r, o_duty_r, o_tlo_r, o_thi_r;
  mmnp_pkg::error_code_t            o_err_r;
  logic                             o_last_r;

  // decode signals
  logic [7:0]                       c;
  logic                             is_digit, eol, dispatch, rec_note, rec_rest;
  logic [3:0]                       dval;
  logic [19:0]                      acc;
  logic [mmnp_pkg::LEN_W-1:0]       lcode, rec_len;
  mmnp_pkg::error_code_t            err;
  logic signed [9:0]                idx_s;
  logic                             idx_ok;
  logic [6:0]                       ix;
  logic [2:0]                       sh;
  logic [10:0]                      period;
  logic [2:0]                       vm;
  logic [7:0]                       duty;

  always_comb begin
    c = in_char_code;
    if (c inside {["A":"Z"]}) c = c + 8'd32;
    is_digit = c inside {["0":"9"]};
    dval     = c[3:0];
    eol      = (c == 8'h0A) || (c == 8'h00);
    acc      = {4'b0, digit_r} * 20'd10 + {16'b0, dval};
    lcode    = mmnp_pkg::length_code(digit_r);

    // pitch of the pending note
    idx_s  = $signed({1'b0, 9'(9'(oct_r) * 9'd12)}) + $signed({{5{semi_r[4]}}, semi_r});
    idx_ok = !idx_s[9] && (idx_s < 10'(PITCH_ENTRIES));
    ix     = idx_s[6:0];
    sh     = '0;
    for (int i = 0; i < 4; i++) begin
      if (ix >= 7'(mmnp_pkg::TABLE_SIZE)) begin
        ix = ix - 7'd12;
        sh = sh + 3'd1;
      end
    end
    period = mmnp_pkg::period_lookup(ix) >> sh;
    duty   = ((vol_r == 5'd31) ? 8'd0 : {3'b0, vol_r}) + mmnp_pkg::DUTY_BASE;

    vm = {1'b0, in_voice};
    for (int i = 0; i < 4; i++) begin
      if (vm >= 3'(VOICES)) vm = vm - 3'(VOICES);
    end

    tempo_nxt  = tempo_r;
    vol_nxt    = vol_r;
    oct_nxt    = oct_r;
    deflen_nxt = deflen_r;
    phase_nxt  = phase_r;
    digit_nxt  = digit_r;
    semi_nxt   = semi_r;
    plen_nxt   = plen_r;
    rec_note   = 1'b0;
    rec_rest   = 1'b0;
    rec_len    = plen_r;
    err        = mmnp_pkg::ERR_NONE;
    dispatch   = 1'b0;

    case (phase_r)
      mmnp_pkg::PH_TEMPO, mmnp_pkg::PH_VOL, mmnp_pkg::PH_LEN, mmnp_pkg::PH_RESTNUM: begin
        if (is_digit) begin
          digit_nxt = (acc > 20'hFFFF) ? 16'hFFFF : acc[15:0];
        end else begin
          case (phase_r)
            mmnp_pkg::PH_TEMPO: begin
              if (digit_r < 16'(mmnp_pkg::MIN_TEMPO) || digit_r > 16'(mmnp_pkg::MAX_TEMPO)) begin
                err = mmnp_pkg::ERR_TEMPO;
              end else begin
                tempo_nxt = digit_r[7:0];
                dispatch  = 1'b1;
              end
            end
            mmnp_pkg::PH_VOL: begin
              if (digit_r > 16'd31) begin
                err = mmnp_pkg::ERR_VOLUME;
              end else begin
                vol_nxt  = digit_r[4:0];
                dispatch = 1'b1;
              end
            end
            mmnp_pkg::PH_LEN: begin
              if (lcode == '0) begin
                err = mmnp_pkg::ERR_NOTELEN;
              end else begin
                deflen_nxt = lcode;
                dispatch   = 1'b1;
              end
            end
            default: begin
              if (lcode == '0) begin
                err = mmnp_pkg::ERR_RESTLEN;
              end else if (c == ".") begin
                plen_nxt  = mmnp_pkg::grow(lcode);
                phase_nxt = mmnp_pkg::PH_RESTDOT;
              end else begin
                rec_rest = 1'b1;
                rec_len  = lcode;
                dispatch = 1'b1;
              end
            end
          endcase
        end
      end
      mmnp_pkg::PH_RESTDOT: begin
        if (c == ".") begin
          plen_nxt = mmnp_pkg::grow(plen_r);
        end else begin
          rec_rest = 1'b1;
          dispatch = 1'b1;
        end
      end
      mmnp_pkg::PH_OCT: begin
        if (is_digit) begin
          oct_nxt   = {1'b0, dval};
          phase_nxt = mmnp_pkg::PH_IDLE;
        end else begin
          err = mmnp_pkg::ERR_OCTAVE;
        end
      end
      mmnp_pkg::PH_NOTEACC, mmnp_pkg::PH_NOTEDOT: begin
        if (phase_r == mmnp_pkg::PH_NOTEACC && (c == "#" || c == "-")) begin
          semi_nxt  = (c == "#") ? semi_r + 5'd1 : semi_r + 5'd31;
          phase_nxt = mmnp_pkg::PH_NOTEDOT;
        end else if (c == ".") begin
          plen_nxt  = mmnp_pkg::grow(plen_r);
          phase_nxt = mmnp_pkg::PH_NOTEDOT;
        end else if (!idx_ok) begin
          err = mmnp_pkg::ERR_PITCH;
        end else begin
          rec_note = 1'b1;
          dispatch = 1'b1;
        end
      end
      default: dispatch = 1'b1;
    endcase

    // character handled on its own
    if (dispatch) begin
      phase_nxt = mmnp_pkg::PH_IDLE;
      if (!eol) begin
        case (c)
          " ": ;
          "t": begin
            phase_nxt = mmnp_pkg::PH_TEMPO;
            digit_nxt = '0;
          end
          "o": phase_nxt = mmnp_pkg::PH_OCT;
          "m": err = mmnp_pkg::ERR_MCMD;
          "v": begin
            phase_nxt = mmnp_pkg::PH_VOL;
            digit_nxt = '0;
          end
          ">": oct_nxt = oct_nxt + 5'd1;
          "<": oct_nxt = oct_nxt + 5'd31;
          "l": begin
            phase_nxt = mmnp_pkg::PH_LEN;
            digit_nxt = '0;
          end
          "p": begin
            phase_nxt = mmnp_pkg::PH_RESTNUM;
            digit_nxt = '0;
          end
          default: begin
            if (c inside {["a":"g"]}) begin
              semi_nxt  = mmnp_pkg::semitone_of(3'(c - "a"));
              plen_nxt  = deflen_nxt;
              phase_nxt = mmnp_pkg::PH_NOTEACC;
            end else begin
              err = mmnp_pkg::ERR_SYNTAX;
            end
          end
        endcase
      end
    end
    if (err != mmnp_pkg::ERR_NONE) phase_nxt = mmnp_pkg::PH_IDLE;
  end

  // frame count from the quotient
  logic [mmnp_pkg::POS_W-1:0] pos_cur;
  logic [24:0]                sum_a, sum_b;
  logic [7:0]                 frames;

  always_comb begin
    pos_cur = pos_r[rvoice_r];
    sum_a   = {1'b0, pos_cur[23:0]} + {1'b0, dvd_r[23:0]} + 25'h8000;
    sum_b   = {1'b0, pos_cur[23:0]} + 25'h8000;
    frames  = sum_a[23:16] - sum_b[23:16];
  end

  logic [8:0] div_trial;
  assign div_trial = {rem_r, dvd_r[mmnp_pkg::PROD_W-1]};

  assign stat.has_rec  = has_rec_r;
  assign stat.has_err  = (err_r != mmnp_pkg::ERR_NONE);
  assign stat.div_last = (cnt_r == mmnp_pkg::CNT_W'(1));
  assign stat.out_free = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r   <= mmnp_pkg::TEMPO_RESET;
      vol_r     <= '0;
      oct_r     <= '0;
      deflen_r  <= mmnp_pkg::LEN_RESET;
      phase_r   <= mmnp_pkg::PH_IDLE;
      digit_r   <= '0;
      semi_r    <= '0;
      plen_r    <= '0;
      halted_r  <= 1'b0;
      has_rec_r <= 1'b0;
      err_r     <= mmnp_pkg::ERR_NONE;
      ov_r      <= 1'b0;
      cnt_r     <= '0;
      for (int i = 0; i < VOICES; i++) pos_r[i] <= '0;
    end else begin
      if (cmd.decode) begin
        has_rec_r <= !halted_r && (rec_note || rec_rest);
        err_r     <= halted_r ? mmnp_pkg::ERR_NONE : err;
        if (!halted_r) begin
          tempo_r  <= tempo_nxt;
          vol_r    <= vol_nxt;
          oct_r    <= oct_nxt;
          deflen_r <= deflen_nxt;
          phase_r  <= phase_nxt;
          digit_r  <= digit_nxt;
          semi_r   <= semi_nxt;
          plen_r   <= plen_nxt;
          halted_r <= (err != mmnp_pkg::ERR_NONE);
        end
      end
      if (cmd.start_mul) begin
        cnt_r <= mmnp_pkg::CNT_W'(mmnp_pkg::PROD_W);
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - mmnp_pkg::CNT_W'(1);
      end
      if (cmd.load_rec) begin
        pos_r[rvoice_r] <= pos_cur + dvd_r[mmnp_pkg::POS_W-1:0];
        has_rec_r       <= 1'b0;
      end
      if (cmd.load_rec || cmd.load_err) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      rkind_r  <= rec_note ? mmnp_pkg::EV_NOTE : mmnp_pkg::EV_REST;
      rlen_r   <= rec_len;
      rvoice_r <= vm[VW-1:0];
      rduty_r  <= rec_note ? duty : 8'd0;
      rtlo_r   <= rec_note ? period[7:0] : 8'd0;
      rthi_r   <= rec_note ? {5'b0, period[10:8]} + mmnp_pkg::HIGH_BASE : 8'd0;
    end
    if (cmd.start_mul) begin
      dvd_r <= mmnp_pkg::FRAME_SCALE * rlen_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (div_trial >= {1'b0, tempo_r}) begin
        rem_r <= 8'(div_trial - {1'b0, tempo_r});
        dvd_r <= {dvd_r[mmnp_pkg::PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= div_trial[7:0];
        dvd_r <= {dvd_r[mmnp_pkg::PROD_W-2:0], 1'b0};
      end
    end
    if (cmd.load_rec) begin
      o_kind_r   <= rkind_r;
      o_frames_r <= frames;
      o_mask_r   <= 8'(8'd3 << {rvoice_r, 1'b0});
      o_duty_r   <= rduty_r;
      o_tlo_r    <= rtlo_r;
      o_thi_r    <= rthi_r;
      o_err_r    <= mmnp_pkg::ERR_NONE;
      o_last_r   <= (err_r == mmnp_pkg::ERR_NONE);
    end else if (cmd.load_err) begin
      o_kind_r   <= mmnp_pkg::EV_ERROR;
      o_frames_r <= '0;
      o_mask_r   <= '0;
      o_duty_r   <= '0;
      o_tlo_r    <= '0;
      o_thi_r    <= '0;
      o_err_r    <= err_r;
      o_last_r   <= 1'b1;
    end
  end

  assign out_valid           = ov_r;
  assign out_event_kind      = o_kind_r;
  assign out_frame_count     = o_frames_r;
  assign out_voice_mask      = o_mask_r;
  assign out_duty_volume     = o_duty_r;
  assign out_sweep_byte      = 1'b0;
  assign out_timer_low       = o_tlo_r;
  assign out_timer_high_load = o_thi_r;
  assign out_error_code      = o_err_r;
  assign out_last            = o_last_r;

endmodule

// ===== rtl/core/music_macro_note_parser_top.sv =====
// Top level of the music-macro note parser: controller plus datapath.
// Depends on mmnp_pkg, mmnp_ctrl and mmnp_dp.
//
// Usage
//   Input channel (in_valid / in_stall): one character of a macro line per
//   transaction, with the sound channel it belongs to. Output channel
//   (out_valid / out_stall): note, rest and error records, up to two per
//   character; out_last marks the final record of a character.
// Sequencing and throughput
//   A character that finishes no note or rest is decoded and dispatched. One that
//   finishes a note or rest passes through decode, dispatch, the 16x24 length
//   scaling, the one-bit-per-cycle restoring divide by tempo, and the record
//   load. An error record is loaded after any note or rest record.
//   The divider sets the rate; one character is in work at a time.
// Reset
//   Synchronous, active low: tempo 120, volume and octave 0, default length
//   one quarter, all channel positions 0, parser idle, not halted.
// Stalls
//   A record waits in the output register while out_stall is high. The next
//   character is still taken and decoded; its record waits for the register.
//   After an error record every later character is taken and dropped.
module music_macro_note_parser_top #(
  parameter int VOICES        = mmnp_pkg::VOICES_DEF,
  parameter int PITCH_ENTRIES = mmnp_pkg::PITCH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic [1:0]  in_voice,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_frame_count,
  output logic [7:0]  out_voice_mask,
  output logic [7:0]  out_duty_volume,
  output logic [0:0]  out_sweep_byte,
  output logic [7:0]  out_timer_low,
  output logic [7:0]  out_timer_high_load,
  output logic [3:0]  out_error_code,
  output logic        out_last
);

  mmnp_pkg::dp_cmd_t  cmd;
  mmnp_pkg::dp_stat_t stat;

  mmnp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mmnp_dp #(
    .VOICES        (VOICES),
    .PITCH_ENTRIES (PITCH_ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_char_code        (in_char_code),
    .in_voice            (in_voice),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_kind      (out_event_kind),
    .out_frame_count     (out_frame_count),
    .out_voice_mask      (out_voice_mask),
    .out_duty_volume     (out_duty_volume),
    .out_sweep_byte      (out_sweep_byte),
    .out_timer_low       (out_timer_low),
    .out_timer_high_load (out_timer_high_load),
    .out_error_code      (out_error_code),
    .out_last            (out_last)
  );

  // error records and only they carry a code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_kind == mmnp_pkg::EV_ERROR) == (out_error_code != 4'd0)))
    else $error("error code and record kind disagree");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_err |=> (out_valid && out_last && out_event_kind == mmnp_pkg::EV_ERROR))
    else $error("error record not final");
  a_rec_kind: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rec |=> (out_valid && out_event_kind != mmnp_pkg::EV_ERROR))
    else $error("note/rest record lost");

endmodule

// ===== tb/tb_music_macro_note_parser_top.sv =====
// Self-checking testbench of the music-macro note parser top level.
// Depends on mmnp_pkg and music_macro_note_parser_top; predicts records in SV.
module tb_music_macro_note_parser_top;

  // Pitch periods of the 72-entry table, kept locally for prediction.
  localparam int PERIODS[72] = '{
    2033, 1928, 1803, 1720, 1620, 1531, 1433, 1363, 1285, 1215, 1140, 1075,
    1016, 955, 908, 853, 804, 760, 716, 677, 638, 604, 570, 537,
    507, 479, 452, 426, 403, 379, 359, 339, 320, 301, 248, 269,
    253, 239, 225, 213, 201, 190, 179, 169, 159, 150, 142, 134,
    126, 119, 112, 106, 100, 94, 89, 84, 79, 75, 70, 66,
    63, 59, 56, 52, 49, 47, 44, 41, 39, 37, 35, 33};
  localparam int CYCLE_LIMIT = 1500000;

  typedef enum int {
    P_IDLE, P_TEMPO, P_OCT, P_VOL, P_LEN, P_RESTNUM, P_RESTDOT, P_NOTEACC, P_NOTEDOT
  } parse_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [1:0] voice;
  } macro_char_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] frames;
    logic [7:0] mask;
    logic [7:0] duty;
    logic [0:0] sweep;
    logic [7:0] tlow;
    logic [7:0] thigh;
    logic [3:0] code;
    logic       last;
  } apu_record_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char_code = '0;
  logic [1:0] in_voice = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_event_kind;
  logic [7:0] out_frame_count, out_voice_mask, out_duty_volume;
  logic [0:0] out_sweep_byte;
  logic [7:0] out_timer_low, out_timer_high_load;
  logic [3:0] out_error_code;
  logic out_last;

  music_macro_note_parser_top u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state mirror
  int unsigned tempo, volume, octave, def_len, pend_semi, pend_len, digits;
  logic [31:0] position[4];
  parse_t phase;
  bit halted;

  macro_char_t  char_queue[$];
  apu_record_t  record_queue[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;         // last part of the run: no idling
  int rx_hold = 0;          // long receiver hold-off, counted down by the monitor
  bit done = 1'b0;

  function automatic int unsigned dot_len(int unsigned l);
    int unsigned s;
    s = l + (l >> 1);
    return s > 24'hFFFFFF ? 24'hFFFFFF : s;
  endfunction

  function automatic int unsigned note_len(int unsigned n);
    case (n)
      1: return 16384;
      2: return 8192;
      4: return 4096;
      8: return 2048;
      16: return 1024;
      default: return 0;
    endcase
  endfunction

  // Frame count advance in Q16.16 for one channel
  function automatic logic [7:0] frames_for(int v, int unsigned len);
    longint unsigned delta, pos, a, b;
    delta = (64'd57600 * len) / tempo;
    pos = position[v];
    a = (pos + delta + 64'h8000) >> 16;
    b = (pos + 64'h8000) >> 16;
    position[v] = pos + delta;
    return 8'(a - b);
  endfunction

  function automatic apu_record_t make_rec(logic [1:0] k, logic [7:0] f, logic [7:0] m,
                                           logic [7:0] d, logic [7:0] tl, logic [7:0] th,
                                           logic [3:0] c);
    apu_record_t r;
    r = '{k, f, m, d, 1'b0, tl, th, c, 1'b0};
    return r;
  endfunction

  task automatic predict_char(macro_char_t it);
    apu_record_t recs[$];
    int unsigned c, v, l, p;
    int semi, idx;
    logic [7:0] mask;
    bit dig, eol, fin;
    mmnp_pkg::error_code_t err;
    c = it.char_code;
    v = it.voice;
    mask = 8'(3 << (2 * v));
    err = mmnp_pkg::ERR_NONE;
    fin = 1'b0;
    if (halted) return;
    if (c >= "A" && c <= "Z") c = c - "A" + "a";
    dig = c >= "0" && c <= "9";
    eol = c == 10 || c == 0;
    case (phase)
      P_TEMPO, P_VOL, P_LEN, P_RESTNUM: begin
        if (dig) begin
          digits = digits * 10 + (c - "0");
          if (digits > 65535) digits = 65535;
          return;
        end
        if (phase == P_TEMPO) begin
          if (digits < mmnp_pkg::MIN_TEMPO || digits > mmnp_pkg::MAX_TEMPO)
            err = mmnp_pkg::ERR_TEMPO;
          else tempo = digits;
        end else if (phase == P_VOL) begin
          if (digits > 31) err = mmnp_pkg::ERR_VOLUME;
          else volume = digits;
        end else if (phase == P_LEN) begin
          l = note_len(digits);
          if (l == 0) err = mmnp_pkg::ERR_NOTELEN;
          else def_len = l;
        end else begin
          l = note_len(digits);
          if (l == 0) err = mmnp_pkg::ERR_RESTLEN;
          else begin
            pend_len = l;
            phase = P_RESTDOT;
          end
        end
        if (err == mmnp_pkg::ERR_NONE && phase == P_RESTDOT) fin = 1'b1;
        else phase = P_IDLE;
      end
      P_RESTDOT: fin = 1'b1;
      P_OCT: begin
        if (dig) begin
          octave = c - "0";
          phase = P_IDLE;
          return;
        end
        err = mmnp_pkg::ERR_OCTAVE;
      end
      P_NOTEACC, P_NOTEDOT: begin
        if (phase == P_NOTEACC && (c == "#" || c == "-")) begin
          pend_semi = (pend_semi + (c == "#" ? 1 : 31)) & 31;
          phase = P_NOTEDOT;
          return;
        end
        if (c == ".") begin
          pend_len = dot_len(pend_len);
          phase = P_NOTEDOT;
          return;
        end
        semi = int'(pend_semi & 15) - int'(pend_semi & 16);
        idx = 12 * int'(octave) + semi;
        phase = P_IDLE;
        if (idx < 0 || idx >= 72) err = mmnp_pkg::ERR_PITCH;
        else begin
          p = PERIODS[idx];
          recs.push_back(make_rec(mmnp_pkg::EV_NOTE, frames_for(v, pend_len), mask,
                                  8'((volume % 31) + 128), 8'(p), 8'((p >> 8) + 48),
                                  mmnp_pkg::ERR_NONE));
        end
      end
      default: phase = P_IDLE;
    endcase
    // rest may absorb dots, otherwise it is emitted here
    if (fin) begin
      if (c == ".") begin
        pend_len = dot_len(pend_len);
        return;
      end
      recs.push_back(make_rec(mmnp_pkg::EV_REST, frames_for(v, pend_len), mask, 0, 0, 0,
                              mmnp_pkg::ERR_NONE));
      phase = P_IDLE;
    end
    if (err == mmnp_pkg::ERR_NONE) begin
      phase = P_IDLE;
      if (!eol) begin
        if (c == " ") begin
        end else if (c == "t") begin
          phase = P_TEMPO;
          digits = 0;
        end else if (c == "o") phase = P_OCT;
        else if (c == "m") err = mmnp_pkg::ERR_MCMD;
        else if (c == "v") begin
          phase = P_VOL;
          digits = 0;
        end else if (c == ">") octave = (octave + 1) & 31;
        else if (c == "<") octave = (octave + 31) & 31;
        else if (c == "l") begin
          phase = P_LEN;
          digits = 0;
        end else if (c == "p") begin
          phase = P_RESTNUM;
          digits = 0;
        end else if (c >= "a" && c <= "g") begin
          pend_semi = mmnp_pkg::semitone_of(3'(c - "a"));
          pend_len = def_len;
          phase = P_NOTEACC;
        end else err = mmnp_pkg::ERR_SYNTAX;
      end
    end
    if (err != mmnp_pkg::ERR_NONE) begin
      recs.push_back(make_rec(mmnp_pkg::EV_ERROR, 0, 0, 0, 0, 0, err));
      halted = 1'b1;
      phase = P_IDLE;
    end
    if (recs.size() > 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) record_queue.push_back(recs[i]);
  endtask

  // Octave 0..5 keeps every note in range; a few escape on purpose.
  function automatic string random_phrase();
    string s, lets;
    int n;
    lets = "abcdefgABCDEFG";
    s = "";
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 11))
        0: s = {s, $sformatf("t%0d",
                             $urandom_range(mmnp_pkg::MIN_TEMPO, mmnp_pkg::MAX_TEMPO))};
        1: s = {s, $sformatf("v%0d", $urandom_range(0, 31))};
        2: s = {s, $sformatf("o%0d", $urandom_range(1, 4))};
        3: s = {s, $sformatf("l%0d", 1 << $urandom_range(0, 4))};
        4: s = {s, $sformatf("p%0d", 1 << $urandom_range(0, 4)),
                $urandom_range(0, 2) == 0 ? ".." : ""};
        5: s = {s, $sformatf("o%0d", $urandom_range(1, 4)),
                ($urandom_range(0, 1) ? ">" : "<")};
        6: s = {s, " "};
        default: begin
          s = {s, string'(lets[$urandom_range(0, 13)])};
          case ($urandom_range(0, 3))
            0: s = {s, "#"};
            1: s = {s, "-"};
            default: ;
          endcase
          if ($urandom_range(0, 3) == 0) s = {s, "."};
        end
      endcase
    end
    return s;
  endfunction

  function automatic macro_char_t mk(int unsigned c);
    macro_char_t it;
    it.char_code = 8'(c);
    it.voice = 2'($urandom_range(0, 3));
    return it;
  endfunction

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) char_queue.push_back(mk(s[i]));
  endtask

  task automatic wait_drained();
    while (char_queue.size() > 0 || record_queue.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Reset restores state; done once, then the session runs on until halted.
  task automatic model_reset();
    tempo = 120;
    volume = 0;
    octave = 0;
    def_len = 4096;
    pend_semi = 0;
    pend_len = 0;
    digits = 0;
    phase = P_IDLE;
    halted = 1'b0;
    foreach (position[i]) position[i] = '0;
  endtask

  task automatic report(string what, apu_record_t got, apu_record_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // Driver: pulls characters from the queue, idles in random bursts.
  // The head of the queue is the character on the pins while in_valid is high.
  int tx_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_char('{in_char_code, in_voice});
        void'(char_queue.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
          tx_gap <= $urandom_range(1, 19);
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          in_valid <= 1'b1;
          {in_char_code, in_voice} <= char_queue[0];
        end else in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted record against the oldest prediction.
  int rx_gap = 0;
  always @(posedge clk) begin
    apu_record_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_event_kind, out_frame_count, out_voice_mask, out_duty_volume,
                out_sweep_byte, out_timer_low, out_timer_high_load, out_error_code,
                out_last};
        if (record_queue.size() == 0) report("unexpected record", got, got);
        else begin
          want = record_queue.pop_front();
          if (got.kind != want.kind) report("event kind", got, want);
          if (got.frames != want.frames) report("frame count", got, want);
          if (got.mask != want.mask) report("voice mask", got, want);
          if (got.duty != want.duty) report("duty volume", got, want);
          if (got.sweep != want.sweep) report("sweep byte", got, want);
          if (got.tlow != want.tlow) report("timer low", got, want);
          if (got.thigh != want.thigh) report("timer high", got, want);
          if (got.code != want.code) report("error code", got, want);
          if (got.last != want.last) report("last flag", got, want);
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        rx_gap <= $urandom_range(1, 19);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT && !done) begin
      $display("tb_music_macro_note_parser_top failed");
      $finish;
    end
  end

  initial begin
    int sent;
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: every command but m, case folding, accidentals, dots, edges of ranges
    queue_text("t250v31o4l16c#.d-e.F G A b p1.. p16 <c >>b\nT30 V0 L1 o0c\n");
    wait_drained();
    // The session halts on its first error, so most random text avoids errors;
    // the long stall lets the block back up while characters keep arriving.
    sent = 0;
    rx_hold <= 400;
    while (sent < 1570) begin
      string s;
      s = random_phrase();
      queue_text(s);
      sent += s.len();
      if ($urandom_range(0, 1)) begin
        char_queue.push_back(mk(10));
        sent++;
      end
      if (sent > 1370) quiet = 1'b1;
      while (char_queue.size() > 40) @(posedge clk);
    end
    wait_drained();
    // Digit saturation gives a bad tempo, which ends the session; later text, bad volume included, is dropped.
    queue_text("t99999999");
    char_queue.push_back(mk(255));
    char_queue.push_back(mk(0));
    queue_text("v99 cde\n");
    wait_drained();
    done = 1'b1;
    if (errors == 0) $display("tb_music_macro_note_parser_top passed");
    else $display("tb_music_macro_note_parser_top failed");
    $finish;
  end

endmodule
